// ----- sv/bss_pkg.sv -----
// Shared types, codes and helpers for the bag/stack store.
// Depends on nothing; every other file of the block imports it.
package bss_pkg;

    localparam int CAPACITY      = 128;
    localparam int WORD_BITS     = 32;
    localparam int CNT_W         = $clog2(CAPACITY + 1);
    localparam int FIELD_W       = 32;
    localparam int COUNT_FIELD_W = 8;

    typedef logic [1:0]           t_cmd_code;
    typedef logic [1:0]           t_status;
    typedef logic [1:0]           t_cell_op;
    typedef logic [WORD_BITS-1:0] t_word;
    typedef logic [CNT_W-1:0]     t_count;

    localparam t_cmd_code CMD_PUSH     = 2'd0;
    localparam t_cmd_code CMD_POP      = 2'd1;
    localparam t_cmd_code CMD_CONTAINS = 2'd2;
    localparam t_cmd_code CMD_REMOVE   = 2'd3;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_FULL     = 2'd1;
    localparam t_status ST_EMPTY    = 2'd2;
    localparam t_status ST_NOTFOUND = 2'd3;

    localparam t_cell_op CELL_HOLD       = 2'd0;
    localparam t_cell_op CELL_FROM_LEFT  = 2'd1;
    localparam t_cell_op CELL_FROM_RIGHT = 2'd2;

    typedef struct packed {
        logic     cmp_en;
        t_cell_op op;
    } t_cell_ctl;

    typedef struct packed {
        t_cmd_code                  cmd;
        logic signed [FIELD_W-1:0]  value;
    } t_cmd_word;

    typedef struct packed {
        logic                       found;
        logic signed [FIELD_W-1:0]  popped_value;
        logic signed [FIELD_W-1:0]  top_value;
        logic [COUNT_FIELD_W-1:0]   entry_count;
        logic                       is_empty;
        t_status                    status;
    } t_result;

    // Input field to stored word: sign-extend or truncate to the word size.
    function automatic t_word to_word(input logic signed [FIELD_W-1:0] v);
        return WORD_BITS'(v);
    endfunction

    // Stored word to output field: sign-extend or truncate to the field size.
    function automatic logic signed [FIELD_W-1:0] to_field(input t_word w);
        return FIELD_W'($signed(w));
    endfunction

endpackage

// ----- sv/bss_cell.sv -----
// One storage cell of the bag/stack store: a word, a neighbor shift and a match flag.
// Depends on bss_pkg.
module bss_cell
    import bss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cell_ctl i_ctl,
    input  logic      i_valid,
    input  t_word     i_key,
    input  t_word     i_left,
    input  t_word     i_right,
    output t_word     o_data,
    output logic      o_hit
);

    t_word r_data;
    logic  r_hit;

    always_ff @(posedge i_clk) begin
        case (i_ctl.op)
            CELL_FROM_LEFT:  r_data <= i_left;
            CELL_FROM_RIGHT: r_data <= i_right;
            default:         r_data <= r_data;
        endcase
    end

    // The match flag only counts for cells that hold a live entry.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit <= 1'b0;
        end else if (i_ctl.cmp_en) begin
            r_hit <= i_valid && (r_data == i_key);
        end
    end

    assign o_data = r_data;
    assign o_hit  = r_hit;

endmodule

// ----- sv/bss_cell_row.sv -----
// Row of storage cells with the shift control and the first-match mask.
// Depends on bss_pkg and bss_cell.
module bss_cell_row
    import bss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmp_en,
    input  logic      i_apply,
    input  t_cmd_code i_cmd,
    input  t_count    i_count,
    input  t_word     i_key,
    output t_word     o_top,
    output logic      o_found
);

    t_word                w_data [CAPACITY];
    logic [CAPACITY-1:0]  w_hit;
    logic [CAPACITY-1:0]  w_rev;
    logic [CAPACITY-1:0]  w_low_up;
    logic [CAPACITY-1:0]  w_above;
    logic                 w_full;
    logic                 w_nonempty;

    assign w_full     = (i_count == CNT_W'(CAPACITY));
    assign w_nonempty = (i_count != '0);
    assign o_found    = |w_hit;
    assign o_top      = w_data[0];

    // Cell 0 is the top; the oldest entry sits at the highest live cell. The
    // first match in push order is therefore the highest matching cell. With
    // the hit vector reversed, the bits from its lowest set bit upward are
    // v | -v, which tells each cell whether a match lies above it.
    assign w_low_up = w_rev | (~w_rev + CAPACITY'(1));

    genvar j;
    generate
        for (j = 0; j < CAPACITY; j++) begin : g_cell
            t_cell_ctl w_ctl;
            t_word     w_left;
            t_word     w_right;

            assign w_rev[j] = w_hit[CAPACITY-1-j];

            if (j < CAPACITY - 1) begin : g_above
                assign w_above[j] = w_low_up[CAPACITY-2-j];
                assign w_right    = w_data[j+1];
            end else begin : g_last
                assign w_above[j] = 1'b0;
                assign w_right    = w_data[j];
            end

            if (j == 0) begin : g_first
                assign w_left = i_key;
            end else begin : g_inner
                assign w_left = w_data[j-1];
            end

            always_comb begin
                w_ctl.cmp_en = i_cmp_en;
                w_ctl.op     = CELL_HOLD;
                if (i_apply) begin
                    case (i_cmd)
                        CMD_PUSH: begin
                            if (!w_full) w_ctl.op = CELL_FROM_LEFT;
                        end
                        CMD_POP: begin
                            if (w_nonempty) w_ctl.op = CELL_FROM_RIGHT;
                        end
                        CMD_REMOVE: begin
                            if (o_found && !w_above[j]) w_ctl.op = CELL_FROM_RIGHT;
                        end
                        default: w_ctl.op = CELL_HOLD;
                    endcase
                end
            end

            bss_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_ctl   (w_ctl),
                .i_valid (i_count > CNT_W'(j)),
                .i_key   (i_key),
                .i_left  (w_left),
                .i_right (w_right),
                .o_data  (w_data[j]),
                .o_hit   (w_hit[j])
            );
        end
    endgenerate

endmodule

// ----- sv/bag_stack_store_unit.sv -----
// Top level of the bag/stack store: command sequencer, fill count and result word.
// Depends on bss_pkg and bss_cell_row.
//
// A fixed store of up to CAPACITY signed words that acts as a stack and as a
// bag. A command word is taken when start is high and busy is low. Push adds
// the value on top, pop removes and returns the top entry, contains searches
// for the value, and remove deletes the oldest entry equal to the value and
// closes the gap. Each command gives exactly one result word, shown for one
// cycle with o_strobe high. A taken command goes through S_CMP, where every
// cell compares its entry with the value, then S_APPLY, where the cell row
// shifts and the count is updated, then S_DONE, which shows the result. The
// receiver cannot stall, so it must take the result in that cycle. busy drops
// in the result cycle, so a new command can be given there.
// Refused commands (push when full, pop when empty, remove with no match)
// leave the store unchanged and report that in the status field.
module bag_stack_store_unit
    import bss_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      start,
    input  t_cmd_word i_cmd,
    output logic      busy,
    output logic      o_strobe,
    output t_result   o_result
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_CMP   = 2'd1;
    localparam logic [1:0] S_APPLY = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0]                r_state;
    logic [1:0]                n_state;
    t_cmd_code                 r_cmd;
    t_word                     r_key;
    t_count                    r_count;
    t_count                    n_count;
    logic                      r_found;
    logic                      n_found;
    logic signed [FIELD_W-1:0] r_popped;
    logic signed [FIELD_W-1:0] n_popped;
    t_status                   r_status;
    t_status                   n_status;

    logic  w_accept;
    t_word w_top;
    logic  w_found;

    assign busy     = r_state inside {S_CMP, S_APPLY};
    assign w_accept = start && !busy;

    // The cell row holds the entries; the sequencer only tells it when to
    // compare and when to shift.
    bss_cell_row u_row (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmp_en (r_state == S_CMP),
        .i_apply  (r_state == S_APPLY),
        .i_cmd    (r_cmd),
        .i_count  (r_count),
        .i_key    (r_key),
        .o_top    (w_top),
        .o_found  (w_found)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE, S_DONE: n_state = w_accept ? S_CMP : S_IDLE;
            S_CMP:          n_state = S_APPLY;
            S_APPLY:        n_state = S_DONE;
            default:        n_state = S_IDLE;
        endcase
    end

    // Outcome of the command, worked out from the count and the match flags
    // as they stand in the apply cycle; the row shifts in the same cycle.
    always_comb begin
        n_count  = r_count;
        n_found  = 1'b0;
        n_popped = '0;
        n_status = ST_OK;
        case (r_cmd)
            CMD_PUSH: begin
                if (r_count == CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (r_count == '0) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count  = r_count - CNT_W'(1);
                    n_popped = to_field(w_top);
                end
            end
            CMD_CONTAINS: begin
                n_found = w_found;
            end
            CMD_REMOVE: begin
                if (w_found) begin
                    n_count = r_count - CNT_W'(1);
                    n_found = 1'b1;
                end else begin
                    n_status = ST_NOTFOUND;
                end
            end
            default: n_status = ST_OK;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_APPLY) begin
                r_count <= n_count;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_cmd.cmd;
            r_key <= to_word(i_cmd.value);
        end
        if (r_state == S_APPLY) begin
            r_found  <= n_found;
            r_popped <= n_popped;
            r_status <= n_status;
        end
    end

    // The top entry is read straight from cell 0 once the row has shifted.
    assign o_strobe              = (r_state == S_DONE);
    assign o_result.found        = r_found;
    assign o_result.popped_value = r_popped;
    assign o_result.top_value    = (r_count != '0) ? to_field(w_top) : '0;
    assign o_result.entry_count  = COUNT_FIELD_W'(r_count);
    assign o_result.is_empty     = (r_count == '0);
    assign o_result.status       = r_status;

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> busy)
        else $error("command taken but block not busy next cycle");

    a_strobe_after_apply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> $past(r_state == S_APPLY))
        else $error("result shown without an apply cycle");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("fill count beyond capacity");

    a_full_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_result.status == ST_FULL)) |-> (r_count == CNT_W'(CAPACITY)))
        else $error("push refused while store not full");

    a_pop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (r_cmd == CMD_POP) && (o_result.status == ST_OK))
            |-> (r_count == $past(r_count) - CNT_W'(1)))
        else $error("pop did not lower the count by one");
`endif

endmodule
